>>> hw/rtl/vnorm_pkg.sv
`timescale 1ns / 1ps

package vnorm_pkg;
    localparam int DEF_COMPONENT_BITS = 32;
    localparam int DEF_FRACTION_BITS  = 16;
    // fixed field widths on the stream ports
    localparam int IN_FIELD_W = 32;
    localparam int LEN_W      = 32;
endpackage

>>> hw/rtl/vnorm_sqrt_cell.sv
`timescale 1ns / 1ps

// one result bit of the square root, bit-pair restoring step
module vnorm_sqrt_cell
    import vnorm_pkg::*;
#(
    parameter int SW     = 64,
    parameter int IDX    = 31,
    parameter int SIDE_W = 99
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              vld_in,
    input  logic [SW-1:0]     rem_in,
    input  logic [SW-1:0]     root_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vld_out,
    output logic [SW-1:0]     rem_out,
    output logic [SW-1:0]     root_out,
    output logic [SIDE_W-1:0] side_out
);
    logic [SW-1:0] bitv;
    logic [SW-1:0] trial;
    logic          ge;
    logic [SW-1:0] rem_next;
    logic [SW-1:0] root_next;
    logic          vld_reg;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] root_reg;
    logic [SIDE_W-1:0] side_reg;

    assign bitv      = SW'(1) << (2 * IDX);
    assign trial     = root_in + bitv;
    assign ge        = rem_in >= trial;
    assign rem_next  = ge ? rem_in - trial : rem_in;
    assign root_next = ge ? (root_in >> 1) + bitv : root_in >> 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;
endmodule

>>> hw/rtl/vnorm_div_cell.sv
`timescale 1ns / 1ps

// one quotient bit for all three lanes, restoring division
module vnorm_div_cell
    import vnorm_pkg::*;
#(
    parameter int CW = 32,
    parameter int QW = 17
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                vld_in,
    input  logic [2:0][CW:0]    r_in,
    input  logic [2:0][QW-1:0]  q_in,
    input  logic [2:0]          neg_in,
    input  logic [CW-1:0]       len_in,
    output logic                vld_out,
    output logic [2:0][CW:0]    r_out,
    output logic [2:0][QW-1:0]  q_out,
    output logic [2:0]          neg_out,
    output logic [CW-1:0]       len_out
);
    logic [2:0][CW:0]   r_next;
    logic [2:0][QW-1:0] q_next;
    logic               vld_reg;
    logic [2:0][CW:0]   r_reg;
    logic [2:0][QW-1:0] q_reg;
    logic [2:0]         neg_reg;
    logic [CW-1:0]      len_reg;

    always_comb begin
        logic [CW:0] diff;
        logic        ge;
        for (int k = 0; k < 3; k++) begin
            ge   = r_in[k] >= {1'b0, len_in};
            diff = ge ? r_in[k] - {1'b0, len_in} : r_in[k];
            r_next[k] = {diff[CW-1:0], 1'b0};
            q_next[k] = {q_in[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
        if (en) begin
            r_reg   <= r_next;
            q_reg   <= q_next;
            neg_reg <= neg_in;
            len_reg <= len_in;
        end
    end

    assign vld_out = vld_reg;
    assign r_out   = r_reg;
    assign q_out   = q_reg;
    assign neg_out = neg_reg;
    assign len_out = len_reg;
endmodule

>>> hw/rtl/vector3_normalize_unit.sv
`timescale 1ns / 1ps

// channel | direction | tdata fields (lsb first)
// s_axis  | in        | comp_x[31:0], comp_y[63:32], comp_z[95:64]
// m_axis  | out       | unit_x, unit_y, unit_z (FRACTION_BITS+2 each), length (32), zero fill
//
// one vector per cycle while the output is not stalled; the square root cell row gives
// one result bit a cell and the divider cell row one quotient bit a cell
// aresetn clears all stage valid bits; data registers are not reset
// a stalled output holds the whole pipeline in place, nothing is dropped
module vector3_normalize_unit
    import vnorm_pkg::*;
#(
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
    parameter int FRACTION_BITS  = DEF_FRACTION_BITS,
    localparam int UW = FRACTION_BITS + 2,
    localparam int MW = ((3 * UW + LEN_W + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [3*IN_FIELD_W-1:0] s_tdata,  // comp_x, comp_y, comp_z
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [MW-1:0]           m_tdata   // unit_x, unit_y, unit_z, length
);
    localparam int C      = COMPONENT_BITS;
    localparam int F      = FRACTION_BITS;
    localparam int SW     = 2 * C;
    localparam int QW     = F + 1;
    localparam int SIDE_W = 3 * C + 3;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // abs and sign
    logic             a_vld_reg;
    logic [2:0][C-1:0] a_abs_reg, a_abs_next;
    logic [2:0]       a_neg_reg, a_neg_next;
    // squares
    logic             b_vld_reg;
    logic [2:0][SW-1:0] b_sq_reg, b_sq_next;
    logic [2:0][C-1:0] b_abs_reg;
    logic [2:0]       b_neg_reg;
    // sum of squares
    logic             c_vld_reg;
    logic [SW-1:0]    c_sum_reg, c_sum_next;
    logic [SIDE_W-1:0] c_side_reg;

    always_comb begin
        logic [C-1:0] v;
        for (int k = 0; k < 3; k++) begin
            v = s_tdata[IN_FIELD_W*k +: C];
            a_neg_next[k] = v[C-1];
            a_abs_next[k] = v[C-1] ? -v : v;
            b_sq_next[k]  = SW'(a_abs_reg[k]) * SW'(a_abs_reg[k]);
        end
        c_sum_next = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_tvalid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
        if (en) begin
            a_abs_reg  <= a_abs_next;
            a_neg_reg  <= a_neg_next;
            b_sq_reg   <= b_sq_next;
            b_abs_reg  <= a_abs_reg;
            b_neg_reg  <= a_neg_reg;
            c_sum_reg  <= c_sum_next;
            c_side_reg <= {b_neg_reg, b_abs_reg};
        end
    end

    // square root cell row, msb first
    logic              sq_vld  [0:C];
    logic [SW-1:0]     sq_rem  [0:C];
    logic [SW-1:0]     sq_root [0:C];
    logic [SIDE_W-1:0] sq_side [0:C];

    assign sq_vld[0]  = c_vld_reg;
    assign sq_rem[0]  = c_sum_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = c_side_reg;

    for (genvar g = 0; g < C; g++) begin : g_sqrt
        vnorm_sqrt_cell #(.SW(SW), .IDX(C - 1 - g), .SIDE_W(SIDE_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .vld_in   (sq_vld[g]),
            .rem_in   (sq_rem[g]),
            .root_in  (sq_root[g]),
            .side_in  (sq_side[g]),
            .vld_out  (sq_vld[g+1]),
            .rem_out  (sq_rem[g+1]),
            .root_out (sq_root[g+1]),
            .side_out (sq_side[g+1])
        );
    end

    // divider cell row, quotient msb first
    logic               dv_vld [0:QW];
    logic [2:0][C:0]    dv_r   [0:QW];
    logic [2:0][QW-1:0] dv_q   [0:QW];
    logic [2:0]         dv_neg [0:QW];
    logic [C-1:0]       dv_len [0:QW];

    for (genvar k = 0; k < 3; k++) begin : g_dv_in
        assign dv_r[0][k] = {1'b0, sq_side[C][C*k +: C]};
    end
    assign dv_vld[0] = sq_vld[C];
    assign dv_q[0]   = '0;
    assign dv_neg[0] = sq_side[C][3*C +: 3];
    assign dv_len[0] = sq_root[C][C-1:0];

    for (genvar g = 0; g < QW; g++) begin : g_div
        vnorm_div_cell #(.CW(C), .QW(QW)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vld_in  (dv_vld[g]),
            .r_in    (dv_r[g]),
            .q_in    (dv_q[g]),
            .neg_in  (dv_neg[g]),
            .len_in  (dv_len[g]),
            .vld_out (dv_vld[g+1]),
            .r_out   (dv_r[g+1]),
            .q_out   (dv_q[g+1]),
            .neg_out (dv_neg[g+1]),
            .len_out (dv_len[g+1])
        );
    end

    // output register
    logic              m_tvalid_reg;
    logic [MW-1:0]     m_tdata_reg, m_tdata_next;
    logic [2:0][UW-1:0] unit_v;

    always_comb begin
        logic [UW-1:0] mag;
        for (int k = 0; k < 3; k++) begin
            mag = {1'b0, dv_q[QW][k]};
            // zero vector: force zero instead of the all-ones quotient
            if (dv_len[QW] == '0) begin
                unit_v[k] = '0;
            end else begin
                unit_v[k] = dv_neg[QW][k] ? -mag : mag;
            end
        end
        m_tdata_next = MW'({LEN_W'(dv_len[QW]), unit_v[2], unit_v[1], unit_v[0]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_vld[QW];
        end
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    logic [UW-1:0] out_ux;
    assign out_ux = m_tdata[UW-1:0];

    a_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3*UW +: LEN_W] == '0) |-> (m_tdata[3*UW-1:0] == '0))
        else $error("zero length must give a zero unit vector");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_ux[UW-1] == 1'b0 && out_ux <= (UW'(1) << F)) ||
                      (out_ux[UW-1] == 1'b1 && (-out_ux) <= (UW'(1) << F))))
        else $error("unit component beyond one");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
endmodule
